[rtl/lsci_pkg.sv]
// ----------------------------------------------------------------------------
// lsci_pkg
// shared constants, codes and types of the line to sphere / cylinder solver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsci_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int DIR_WIDTH     = 18;
  localparam int DIR_FRAC      = 16;
  localparam int A_WIDTH       = 2 * DIR_WIDTH;
  localparam int CFG_IDX_WIDTH = 3;
  localparam int STATUS_WIDTH  = 2;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5
  } cfg_reg_t;

  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_MISS  = 2'd0,
    ST_HIT   = 2'd1,
    ST_DEGEN = 2'd2
  } status_t;

  typedef struct packed {
    logic vld;
    logic degen;
    logic miss;
  } ctl_t;

endpackage

`default_nettype wire

[rtl/lsci_front.sv]
// ----------------------------------------------------------------------------
// lsci_front
// coefficient pipeline: offsets, dot products and the discriminant
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsci_front #(
  parameter int COORD_WIDTH = lsci_pkg::COORD_WIDTH
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   vld_i,
  input  logic                                   mode_i,
  input  logic signed [COORD_WIDTH-1:0]          center_x_i,
  input  logic signed [COORD_WIDTH-1:0]          center_y_i,
  input  logic signed [COORD_WIDTH-1:0]          center_z_i,
  input  logic        [COORD_WIDTH-2:0]          radius_i,
  input  logic signed [COORD_WIDTH-1:0]          origin_x_i,
  input  logic signed [COORD_WIDTH-1:0]          origin_y_i,
  input  logic signed [COORD_WIDTH-1:0]          origin_z_i,
  input  logic signed [lsci_pkg::DIR_WIDTH-1:0]  dir_x_i,
  input  logic signed [lsci_pkg::DIR_WIDTH-1:0]  dir_y_i,
  input  logic signed [lsci_pkg::DIR_WIDTH-1:0]  dir_z_i,
  output lsci_pkg::ctl_t                         ctl_o,
  output logic        [lsci_pkg::A_WIDTH-1:0]    a_o,
  output logic signed [COORD_WIDTH+19:0]         b_o,
  output logic        [2*COORD_WIDTH+38:0]       d_o
);

  localparam int W   = COORD_WIDTH;
  localparam int VW  = lsci_pkg::DIR_WIDTH;
  localparam int AW  = lsci_pkg::A_WIDTH;
  localparam int AH  = AW / 2;
  localparam int KW  = W + 1;
  localparam int KVW = KW + VW;
  localparam int KKW = 2 * KW;
  localparam int RRW = 2 * (W - 1);
  localparam int BW  = W + 20;
  localparam int CW2 = 2 * W + 3;
  localparam int DW  = 2 * W + 40;
  localparam int H   = BW / 2;
  localparam int P   = (CW2 + 1) / 3;
  localparam int BBW = 4 * H;
  localparam int PCW = AH + P;
  localparam int ACLW = 3 * P + AH;
  localparam int ACW = AW + 3 * P;

  // stage 1
  logic                 v1_r, cyl1_r;
  logic signed [KW-1:0] kx1_r, ky1_r, kz1_r;
  logic [W-2:0]         r1_r;
  // stage 2
  logic                  v2_r;
  logic signed [KVW-1:0] kvx2_r, kvy2_r, kvz2_r;
  logic signed [KKW-1:0] kkx2_r, kky2_r, kkz2_r;
  logic [RRW-1:0]        rr2_r;
  logic [AW-1:0]         vvx2_r, vvy2_r, vvz2_r;
  logic signed [AW-1:0]  vvx_s, vvy_s, vvz_s;
  // stage 3
  logic                  v3_r;
  logic [AW-1:0]         a3_r;
  logic signed [BW-1:0]  b3_r;
  logic signed [CW2-1:0] c3_r;
  // stage 4
  logic                  v4_r, degen4_r, cneg4_r;
  logic [AW-1:0]         a4_r;
  logic signed [BW-1:0]  b4_r;
  logic [BW-2:0]         bm4_r;
  logic [CW2-2:0]        cm4_r;
  // stage 5
  logic                  v5_r, degen5_r, cneg5_r;
  logic [AW-1:0]         a5_r;
  logic signed [BW-1:0]  b5_r;
  logic [2*H-1:0]        pll5_r, phl5_r, phh5_r;
  logic [1:0][2:0][PCW-1:0] pac5_r;
  logic [2*H-1:0]        bme;
  logic [3*P-1:0]        cme;
  // stage 6
  logic                  v6_r, degen6_r, cneg6_r;
  logic [AW-1:0]         a6_r;
  logic signed [BW-1:0]  b6_r;
  logic [BBW-1:0]        bb6_r;
  logic [ACLW-1:0]       aclo6_r, achi6_r;
  // stage 7
  logic                  v7_r, degen7_r, cneg7_r;
  logic [AW-1:0]         a7_r;
  logic signed [BW-1:0]  b7_r;
  logic [BBW-1:0]        bb7_r;
  logic [ACW-1:0]        ac7_r;
  // stage 8
  logic                  v8_r, degen8_r, miss8_r;
  logic [AW-1:0]         a8_r;
  logic signed [BW-1:0]  b8_r;
  logic [DW-2:0]         d8_r;
  logic [DW-1:0]         d_s;

  assign vvx_s = dir_x_i * dir_x_i;
  assign vvy_s = dir_y_i * dir_y_i;
  assign vvz_s = dir_z_i * dir_z_i;
  assign bme   = (2*H)'(bm4_r);
  assign cme   = (3*P)'(cm4_r);
  assign d_s   = cneg7_r ? (DW'(bb7_r) + DW'(ac7_r)) : (DW'(bb7_r) - DW'(ac7_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else begin
      v1_r <= vld_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    // offsets from the surface center
    cyl1_r <= mode_i;
    kx1_r  <= KW'(origin_x_i) - KW'(center_x_i);
    ky1_r  <= KW'(origin_y_i) - KW'(center_y_i);
    kz1_r  <= KW'(origin_z_i) - KW'(center_z_i);
    r1_r   <= radius_i;
    // products, z terms dropped for the cylinder
    kvx2_r <= kx1_r * dir_x_i;
    kvy2_r <= ky1_r * dir_y_i;
    kvz2_r <= cyl1_r ? KVW'(0) : kz1_r * dir_z_i;
    kkx2_r <= kx1_r * kx1_r;
    kky2_r <= ky1_r * ky1_r;
    kkz2_r <= cyl1_r ? KKW'(0) : kz1_r * kz1_r;
    rr2_r  <= r1_r * r1_r;
    vvx2_r <= vvx_s;
    vvy2_r <= vvy_s;
    vvz2_r <= cyl1_r ? '0 : vvz_s;
    // coefficients
    a3_r <= vvx2_r + vvy2_r + vvz2_r;
    b3_r <= BW'(kvx2_r) + BW'(kvy2_r) + BW'(kvz2_r);
    c3_r <= CW2'(kkx2_r) + CW2'(kky2_r) + CW2'(kkz2_r) - $signed(CW2'(rr2_r));
    // magnitudes
    a4_r     <= a3_r;
    b4_r     <= b3_r;
    degen4_r <= (a3_r == '0);
    bm4_r    <= b3_r[BW-1] ? (BW-1)'(-b3_r) : (BW-1)'(b3_r);
    cneg4_r  <= c3_r[CW2-1];
    cm4_r    <= c3_r[CW2-1] ? (CW2-1)'(-c3_r) : (CW2-1)'(c3_r);
    // partial products
    a5_r     <= a4_r;
    b5_r     <= b4_r;
    degen5_r <= degen4_r;
    cneg5_r  <= cneg4_r;
    pll5_r   <= bme[H-1:0] * bme[H-1:0];
    phl5_r   <= bme[2*H-1:H] * bme[H-1:0];
    phh5_r   <= bme[2*H-1:H] * bme[2*H-1:H];
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 3; j++) begin
        pac5_r[i][j] <= PCW'(a4_r[i*AH +: AH]) * PCW'(cme[j*P +: P]);
      end
    end
    // partial sums
    a6_r     <= a5_r;
    b6_r     <= b5_r;
    degen6_r <= degen5_r;
    cneg6_r  <= cneg5_r;
    bb6_r    <= BBW'(pll5_r) + (BBW'(phl5_r) << (H + 1)) + (BBW'(phh5_r) << (2 * H));
    aclo6_r  <= ACLW'(pac5_r[0][0]) + (ACLW'(pac5_r[0][1]) << P)
              + (ACLW'(pac5_r[0][2]) << (2 * P));
    achi6_r  <= ACLW'(pac5_r[1][0]) + (ACLW'(pac5_r[1][1]) << P)
              + (ACLW'(pac5_r[1][2]) << (2 * P));
    a7_r     <= a6_r;
    b7_r     <= b6_r;
    degen7_r <= degen6_r;
    cneg7_r  <= cneg6_r;
    bb7_r    <= bb6_r;
    ac7_r    <= ACW'(aclo6_r) + (ACW'(achi6_r) << AH);
    // discriminant, clamped for the root chain
    a8_r     <= a7_r;
    b8_r     <= b7_r;
    degen8_r <= degen7_r;
    miss8_r  <= d_s[DW-1];
    d8_r     <= d_s[DW-1] ? '0 : d_s[DW-2:0];
  end

  assign ctl_o = '{vld: v8_r, degen: degen8_r, miss: miss8_r};
  assign a_o   = a8_r;
  assign b_o   = b8_r;
  assign d_o   = d8_r;

endmodule

`default_nettype wire

[rtl/lsci_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// lsci_sqrt_cell
// one bit of the integer square root of the discriminant
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsci_sqrt_cell #(
  parameter int DW = 104,
  parameter int SW = 52,
  parameter int BW = 52,
  parameter int J  = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lsci_pkg::ctl_t                ctl_i,
  input  logic [lsci_pkg::A_WIDTH-1:0]  a_i,
  input  logic signed [BW-1:0]          b_i,
  input  logic [DW-2:0]                 rem_i,
  input  logic [SW-1:0]                 root_i,
  output lsci_pkg::ctl_t                ctl_o,
  output logic [lsci_pkg::A_WIDTH-1:0]  a_o,
  output logic signed [BW-1:0]          b_o,
  output logic [DW-2:0]                 rem_o,
  output logic [SW-1:0]                 root_o
);

  logic [DW-1:0] trial, remx;
  logic          take;

  assign trial = (DW'(root_i) << (J + 1)) + (DW'(1) << (2 * J));
  assign remx  = DW'(rem_i);
  assign take  = (remx >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    a_o    <= a_i;
    b_o    <= b_i;
    rem_o  <= take ? (DW-1)'(remx - trial) : rem_i;
    root_o <= take ? (root_i | (SW'(1) << J)) : root_i;
  end

endmodule

`default_nettype wire

[rtl/lsci_div_cell.sv]
// ----------------------------------------------------------------------------
// lsci_div_cell
// one quotient bit of both root divisions by the leading coefficient
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsci_div_cell #(
  parameter int MW = 69,
  parameter int J  = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lsci_pkg::ctl_t                ctl_i,
  input  logic [lsci_pkg::A_WIDTH-1:0]  a_i,
  input  logic [1:0]                    neg_i,
  input  logic [1:0][MW-1:0]            rem_i,
  input  logic [1:0][MW-1:0]            q_i,
  output lsci_pkg::ctl_t                ctl_o,
  output logic [lsci_pkg::A_WIDTH-1:0]  a_o,
  output logic [1:0]                    neg_o,
  output logic [1:0][MW-1:0]            rem_o,
  output logic [1:0][MW-1:0]            q_o
);

  localparam int XW = MW + lsci_pkg::A_WIDTH;

  logic [XW-1:0] dsh;

  assign dsh = XW'(a_i) << J;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    a_o   <= a_i;
    neg_o <= neg_i;
    for (int l = 0; l < 2; l++) begin
      if (XW'(rem_i[l]) >= dsh) begin
        rem_o[l] <= rem_i[l] - dsh[MW-1:0];
        q_o[l]   <= q_i[l] | (MW'(1) << J);
      end else begin
        rem_o[l] <= rem_i[l];
        q_o[l]   <= q_i[l];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/line_sphere_cylinder_intersection.sv]
// ----------------------------------------------------------------------------
// line_sphere_cylinder_intersection
// crossings of a configured 3D line with a sphere or a vertical cylinder
//
//  channel  handshake                 payload
//  input    start / busy              in_mode, in_center_x/y/z, in_radius
//  result   out_valid (strobe)        out_status, out_t_first, out_t_second
//  config   cfg_valid / cfg_ready     cfg_index, cfg_data
//
//  one transfer per cycle on the input; busy stays low
//  pipeline: 8 coefficient stages, one root cell per root bit (COORD_WIDTH+20),
//  2 numerator stages, one divider cell per quotient bit (COORD_WIDTH+37) and
//  the output register
//  reset is synchronous and clears the valid chain and the configuration registers
//  the receiver cannot stall, so results leave on a fixed schedule
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module line_sphere_cylinder_intersection #(
  parameter  int COORD_WIDTH    = lsci_pkg::COORD_WIDTH,
  localparam int CFG_DATA_WIDTH = (COORD_WIDTH > lsci_pkg::DIR_WIDTH) ?
                                  COORD_WIDTH : lsci_pkg::DIR_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_mode,
  input  logic signed [COORD_WIDTH-1:0]         in_center_x,
  input  logic signed [COORD_WIDTH-1:0]         in_center_y,
  input  logic signed [COORD_WIDTH-1:0]         in_center_z,
  input  logic        [COORD_WIDTH-2:0]         in_radius,
  output logic                                  out_valid,
  output logic [lsci_pkg::STATUS_WIDTH-1:0]     out_status,
  output logic signed [COORD_WIDTH-1:0]         out_t_first,
  output logic signed [COORD_WIDTH-1:0]         out_t_second,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lsci_pkg::CFG_IDX_WIDTH-1:0]    cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]             cfg_data
);

  localparam int W  = COORD_WIDTH;
  localparam int VW = lsci_pkg::DIR_WIDTH;
  localparam int AW = lsci_pkg::A_WIDTH;
  localparam int BW = W + 20;
  localparam int DW = 2 * W + 40;
  localparam int SW = W + 20;
  localparam int NW = W + 22;
  localparam int MW = W + 37;
  localparam int FR = lsci_pkg::DIR_FRAC;

  logic signed [W-1:0]  origin_x_r, origin_y_r, origin_z_r;
  logic signed [VW-1:0] dir_x_r, dir_y_r, dir_z_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      origin_z_r <= '0;
      dir_x_r    <= VW'(1 << FR);
      dir_y_r    <= '0;
      dir_z_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (lsci_pkg::cfg_reg_t'(cfg_index))
        lsci_pkg::REG_ORIGIN_X: origin_x_r <= cfg_data[W-1:0];
        lsci_pkg::REG_ORIGIN_Y: origin_y_r <= cfg_data[W-1:0];
        lsci_pkg::REG_ORIGIN_Z: origin_z_r <= cfg_data[W-1:0];
        lsci_pkg::REG_DIR_X:    dir_x_r    <= cfg_data[VW-1:0];
        lsci_pkg::REG_DIR_Y:    dir_y_r    <= cfg_data[VW-1:0];
        lsci_pkg::REG_DIR_Z:    dir_z_r    <= cfg_data[VW-1:0];
        default: ;
      endcase
    end
  end

  // coefficient pipeline
  lsci_pkg::ctl_t       sq_ctl [SW+1];
  logic [AW-1:0]        sq_a   [SW+1];
  logic signed [BW-1:0] sq_b   [SW+1];
  logic [DW-2:0]        sq_rem [SW+1];
  logic [SW-1:0]        sq_root[SW+1];

  lsci_front #(.COORD_WIDTH(W)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .vld_i      (start && !busy),
    .mode_i     (in_mode),
    .center_x_i (in_center_x),
    .center_y_i (in_center_y),
    .center_z_i (in_center_z),
    .radius_i   (in_radius),
    .origin_x_i (origin_x_r),
    .origin_y_i (origin_y_r),
    .origin_z_i (origin_z_r),
    .dir_x_i    (dir_x_r),
    .dir_y_i    (dir_y_r),
    .dir_z_i    (dir_z_r),
    .ctl_o      (sq_ctl[0]),
    .a_o        (sq_a[0]),
    .b_o        (sq_b[0]),
    .d_o        (sq_rem[0])
  );

  assign sq_root[0] = '0;

  // square root chain, most significant bit first
  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    lsci_sqrt_cell #(.DW(DW), .SW(SW), .BW(BW), .J(SW - 1 - i)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (sq_ctl[i]),
      .a_i    (sq_a[i]),
      .b_i    (sq_b[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .ctl_o  (sq_ctl[i+1]),
      .a_o    (sq_a[i+1]),
      .b_o    (sq_b[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1])
    );
  end

  // numerators -b + s and -b - s
  lsci_pkg::ctl_t  n1_ctl_r, n2_ctl_r;
  logic [AW-1:0]   n1_a_r, n2_a_r;
  logic [NW-1:0]   n1_p_r, n1_m_r;
  logic [NW-1:0]   bx, sx;
  logic [1:0]      n2_neg_r;
  logic [1:0][MW-1:0] n2_mag_r;
  logic [NW-1:0]   np_abs, nm_abs;

  assign bx     = NW'(sq_b[SW]);
  assign sx     = NW'(sq_root[SW]);
  assign np_abs = n1_p_r[NW-1] ? (NW'(0) - n1_p_r) : n1_p_r;
  assign nm_abs = n1_m_r[NW-1] ? (NW'(0) - n1_m_r) : n1_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n1_ctl_r <= '0;
      n2_ctl_r <= '0;
    end else begin
      n1_ctl_r <= sq_ctl[SW];
      n2_ctl_r <= n1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    n1_a_r      <= sq_a[SW];
    n1_p_r      <= sx - bx;
    n1_m_r      <= NW'(0) - sx - bx;
    n2_a_r      <= n1_a_r;
    n2_neg_r    <= {n1_m_r[NW-1], n1_p_r[NW-1]};
    n2_mag_r[0] <= {np_abs[NW-2:0], {FR{1'b0}}};
    n2_mag_r[1] <= {nm_abs[NW-2:0], {FR{1'b0}}};
  end

  // division chain, most significant quotient bit first
  lsci_pkg::ctl_t      dv_ctl[MW+1];
  logic [AW-1:0]       dv_a  [MW+1];
  logic [1:0]          dv_neg[MW+1];
  logic [1:0][MW-1:0]  dv_rem[MW+1];
  logic [1:0][MW-1:0]  dv_q  [MW+1];

  assign dv_ctl[0] = n2_ctl_r;
  assign dv_a[0]   = n2_a_r;
  assign dv_neg[0] = n2_neg_r;
  assign dv_rem[0] = n2_mag_r;
  assign dv_q[0]   = '0;

  for (genvar i = 0; i < MW; i++) begin : g_div
    lsci_div_cell #(.MW(MW), .J(MW - 1 - i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (dv_ctl[i]),
      .a_i   (dv_a[i]),
      .neg_i (dv_neg[i]),
      .rem_i (dv_rem[i]),
      .q_i   (dv_q[i]),
      .ctl_o (dv_ctl[i+1]),
      .a_o   (dv_a[i+1]),
      .neg_o (dv_neg[i+1]),
      .rem_o (dv_rem[i+1]),
      .q_o   (dv_q[i+1])
    );
  end

  // floor rounding and saturation
  logic [1:0][W-1:0] t_sat;
  logic [MW:0]       qq     [2];
  logic [MW:0]       qq_neg [2];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      qq[l]     = {1'b0, dv_q[MW][l]} + (MW+1)'(dv_rem[MW][l] != '0);
      qq_neg[l] = ~qq[l] + (MW+1)'(1);
      if (!dv_neg[MW][l]) begin
        t_sat[l] = (dv_q[MW][l][MW-1:W-1] != '0) ? {1'b0, {(W-1){1'b1}}}
                                                  : dv_q[MW][l][W-1:0];
      end else begin
        t_sat[l] = (qq[l] > ((MW+1)'(1) << (W - 1))) ? {1'b1, {(W-1){1'b0}}}
                                                     : qq_neg[l][W-1:0];
      end
    end
  end

  logic                             out_valid_r;
  logic [lsci_pkg::STATUS_WIDTH-1:0] out_status_r;
  logic [W-1:0]                      out_t_first_r, out_t_second_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_ctl[MW].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_ctl[MW].degen) begin
      out_status_r   <= lsci_pkg::ST_DEGEN;
      out_t_first_r  <= '0;
      out_t_second_r <= '0;
    end else if (dv_ctl[MW].miss) begin
      out_status_r   <= lsci_pkg::ST_MISS;
      out_t_first_r  <= '0;
      out_t_second_r <= '0;
    end else begin
      out_status_r   <= lsci_pkg::ST_HIT;
      out_t_first_r  <= t_sat[0];
      out_t_second_r <= t_sat[1];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_t_first  = out_t_first_r;
  assign out_t_second = out_t_second_r;

endmodule

`default_nettype wire

[dv/lsci_checker.sv]
// ----------------------------------------------------------------------------
// lsci_checker
// watches the query, result and register channels of the line crossing
// solver, predicts each result from its own register copy and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsci_checker
  import lsci_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          in_mode,
  input  logic signed [COORD_WIDTH-1:0] in_center_x,
  input  logic signed [COORD_WIDTH-1:0] in_center_y,
  input  logic signed [COORD_WIDTH-1:0] in_center_z,
  input  logic        [COORD_WIDTH-2:0] in_radius,
  input  logic                          out_valid,
  input  logic [STATUS_WIDTH-1:0]       out_status,
  input  logic signed [COORD_WIDTH-1:0] out_t_first,
  input  logic signed [COORD_WIDTH-1:0] out_t_second,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [CFG_IDX_WIDTH-1:0]      cfg_index,
  input  logic [COORD_WIDTH-1:0]        cfg_data,
  output int                            fail_count,
  output int                            pending,
  output int                            hit_count,
  output int                            degen_count
);

  typedef struct {
    status_t                  status;
    logic signed [COORD_WIDTH-1:0] t_first;
    logic signed [COORD_WIDTH-1:0] t_second;
  } crossing_t;

  logic signed [COORD_WIDTH-1:0] org_x, org_y, org_z;
  logic signed [DIR_WIDTH-1:0]   dir_x, dir_y, dir_z;
  crossing_t                     crossings_due[$];

  function automatic logic signed [COORD_WIDTH-1:0] root_to_t(
    logic signed [127:0] num, logic signed [127:0] a);
    logic signed [127:0] q;
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = (128'sd1 <<< (COORD_WIDTH - 1)) - 1;
    lo = -(128'sd1 <<< (COORD_WIDTH - 1));
    num = num <<< DIR_FRAC;
    q = num / a;
    if (num < 0 && (num % a) != 0) q = q - 1;
    if (q > hi) q = hi;
    if (q < lo) q = lo;
    return q[COORD_WIDTH-1:0];
  endfunction

  function automatic crossing_t solve_crossing(
    logic mode, logic signed [COORD_WIDTH-1:0] cx, logic signed [COORD_WIDTH-1:0] cy,
    logic signed [COORD_WIDTH-1:0] cz, logic [COORD_WIDTH-2:0] r);
    logic signed [127:0] kx, ky, kz, vx, vy, vz, rr, a, b, c, d;
    logic [127:0] s, cand, ud;
    crossing_t res;
    kx = org_x; kx = kx - cx;
    ky = org_y; ky = ky - cy;
    kz = org_z; kz = kz - cz;
    vx = dir_x; vy = dir_y; vz = dir_z;
    rr = {1'b0, r};
    a = vx * vx + vy * vy;
    b = kx * vx + ky * vy;
    c = kx * kx + ky * ky;
    if (!mode) begin
      a = a + vz * vz;
      b = b + kz * vz;
      c = c + kz * kz;
    end
    c = c - rr * rr;
    res.status = ST_MISS;
    res.t_first = '0;
    res.t_second = '0;
    if (a == 0) begin
      res.status = ST_DEGEN;
      return res;
    end
    d = b * b - a * c;
    if (d < 0) return res;
    ud = d;
    s = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = s | (128'd1 << i);
      if (cand * cand <= ud) s = cand;
    end
    res.status = ST_HIT;
    res.t_first = root_to_t(-b + $signed(s), a);
    res.t_second = root_to_t(-b - $signed(s), a);
    return res;
  endfunction

  always @(posedge clk) begin
    crossing_t want;
    if (!rst_n) begin
      org_x <= '0; org_y <= '0; org_z <= '0;
      dir_x <= 18'sd65536; dir_y <= '0; dir_z <= '0;
      crossings_due.delete();
      pending <= 0;
      fail_count <= 0;
      hit_count <= 0;
      degen_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_ORIGIN_X: org_x <= cfg_data;
          REG_ORIGIN_Y: org_y <= cfg_data;
          REG_ORIGIN_Z: org_z <= cfg_data;
          REG_DIR_X:    dir_x <= cfg_data[DIR_WIDTH-1:0];
          REG_DIR_Y:    dir_y <= cfg_data[DIR_WIDTH-1:0];
          REG_DIR_Z:    dir_z <= cfg_data[DIR_WIDTH-1:0];
          default: ;
        endcase
      end
      if (start && !busy)
        crossings_due.push_back(solve_crossing(in_mode, in_center_x, in_center_y,
                                               in_center_z, in_radius));
      if (out_valid) begin
        if (crossings_due.size() == 0) begin
          $display("%0t: result with none expected: status %0d t1 %0d t2 %0d",
                   $time, out_status, out_t_first, out_t_second);
          fail_count <= fail_count + 1;
        end else begin
          want = crossings_due.pop_front();
          if (want.status == ST_HIT) hit_count <= hit_count + 1;
          if (want.status == ST_DEGEN) degen_count <= degen_count + 1;
          if (out_status !== want.status || out_t_first !== want.t_first ||
              out_t_second !== want.t_second) begin
            $display("%0t: mismatch expected status %0d t1 %0d t2 %0d, got %0d %0d %0d",
                     $time, want.status, want.t_first, want.t_second,
                     out_status, out_t_first, out_t_second);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= crossings_due.size();
    end
  end

endmodule

`default_nettype wire

[dv/line_sphere_cylinder_intersection_tb.sv]
// ----------------------------------------------------------------------------
// line_sphere_cylinder_intersection_tb
// directed and random crossing queries over several line settings, with
// random sender gaps; results are checked by lsci_checker
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module line_sphere_cylinder_intersection_tb;
  import lsci_pkg::*;

  localparam logic [CFG_IDX_WIDTH-1:0] UNUSED_INDEX = 3'd6;
  localparam int SPHERE = 0;
  localparam int CYLINDER = 1;
  localparam int STALL_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_mode = 1'b0;
  logic signed [COORD_WIDTH-1:0] in_center_x = '0, in_center_y = '0, in_center_z = '0;
  logic [COORD_WIDTH-2:0] in_radius = '0;
  logic out_valid;
  logic [STATUS_WIDTH-1:0] out_status;
  logic signed [COORD_WIDTH-1:0] out_t_first, out_t_second;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
  logic [COORD_WIDTH-1:0] cfg_data = '0;
  int fail_count, pending, hit_count, degen_count;
  int gap_pct, queries_sent, reg_writes, quiet_cycles;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  line_sphere_cylinder_intersection dut (.*);

  lsci_checker checker_i (.*);

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  task automatic send_query(int mode, logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                            logic [30:0] r);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_mode <= mode[0];
    in_center_x <= cx;
    in_center_y <= cy;
    in_center_z <= cz;
    in_radius <= r;
    @(negedge clk);
    while (busy) @(negedge clk);
    queries_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    cfg_valid <= 1'b0;
    reg_writes++;
    @(negedge clk);
  endtask

  task automatic set_line(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                          int vx, int vy, int vz);
    drain();
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_DIR_X, vx);
    write_reg(REG_DIR_Y, vy);
    write_reg(REG_DIR_Z, vz);
  endtask

  function automatic int rand_dir();
    case ($urandom_range(5))
      0: return 65536;
      1: return -65536;
      2: return 0;
      default: return int'($urandom_range(131072)) - 65536;
    endcase
  endfunction

  function automatic logic [31:0] near(logic [31:0] base);
    return base + $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
  endfunction

  initial begin
    logic [31:0] ox, oy, oz;
    gap_pct = 26;
    queries_sent = 0;
    reg_writes = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // default line along +x through the origin
    send_query(SPHERE, 32'h000a_0000, 0, 0, 31'h0002_0000);
    send_query(SPHERE, 32'h000a_0000, 32'h0005_0000, 0, 31'h0002_0000);
    send_query(SPHERE, 32'h000a_0000, 32'h0002_0000, 0, 31'h0002_0000);
    send_query(CYLINDER, 32'hfff6_0000, 32'h0001_0000, 32'h7fff_ffff, 31'h0003_0000);
    send_query(SPHERE, 0, 0, 0, 0);
    send_query(SPHERE, 32'h7fff_ffff, 0, 0, 31'h7fff_ffff);
    send_query(SPHERE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff);
    send_query(CYLINDER, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff);
    send_query(SPHERE, 32'h8000_0000, 0, 0, 31'h0000_0001);
    drain();
    write_reg(UNUSED_INDEX, 32'hffff_ffff);

    // vertical line: cylinder is degenerate, sphere is not
    set_line(0, 0, 0, 0, 0, 65536);
    send_query(CYLINDER, 0, 0, 0, 31'h0001_0000);
    send_query(SPHERE, 0, 0, 32'h0004_0000, 31'h0001_0000);
    // zero direction, both modes degenerate
    set_line(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0);
    send_query(SPHERE, 0, 0, 0, 31'h7fff_ffff);
    send_query(CYLINDER, 0, 0, 0, 0);
    // tiny direction and far surface: roots saturate
    set_line(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, -1, 1);
    send_query(SPHERE, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
    send_query(CYLINDER, 32'h7fff_ffff, 32'h8000_0000, 0, 31'h7fff_ffff);
    // oversized direction used as given
    set_line(0, 0, 0, -65536, -65536, -65536);
    send_query(SPHERE, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 31'h0003_0000);
    send_query(CYLINDER, 32'hffff_0000, 32'h0002_0000, 0, 31'h0005_0000);

    for (int blk = 0; blk < 9; blk++) begin
      if (blk == 3) gap_pct = 81;
      if (blk == 6) gap_pct = 0;
      if (blk % 3 == 0) begin
        ox = $urandom; oy = $urandom; oz = $urandom;
      end else begin
        ox = near(0); oy = near(0); oz = near(0);
      end
      set_line(ox, oy, oz, rand_dir(), rand_dir(), rand_dir());
      for (int n = 0; n < 50; n++) begin
        if ($urandom_range(3) == 0)
          send_query($urandom_range(1), $urandom, $urandom, $urandom, 31'($urandom));
        else
          send_query($urandom_range(1), near(ox), near(oy), near(oz),
                     31'($urandom_range(31'h0030_0000)));
      end
    end

    drain();
    repeat (200) @(negedge clk);
    $display("ran %0d queries across %0d register writes: %0d crossings, %0d degenerate",
             queries_sent, reg_writes, hit_count, degen_count);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
